[hdl/segx_pkg.sv]
package segx_pkg;

    // number of orientation tests per segment pair
    localparam int NUM_ORIENT = 4;

    // per-stage handshake control handed from the top level to each stage
    typedef struct packed {
        logic en;
        logic vld;
    } t_pipe_ctl;

endpackage

[hdl/segx_diff.sv]
module segx_diff
    import segx_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_pipe_ctl                    i_ctl,
    input  logic signed [COORD_BITS-1:0] i_ax0,
    input  logic signed [COORD_BITS-1:0] i_ay0,
    input  logic signed [COORD_BITS-1:0] i_ax1,
    input  logic signed [COORD_BITS-1:0] i_ay1,
    input  logic signed [COORD_BITS-1:0] i_bx0,
    input  logic signed [COORD_BITS-1:0] i_by0,
    input  logic signed [COORD_BITS-1:0] i_bx1,
    input  logic signed [COORD_BITS-1:0] i_by1,
    output logic                         o_vld,
    output logic signed [COORD_BITS:0]   o_dqx[NUM_ORIENT],
    output logic signed [COORD_BITS:0]   o_dqy[NUM_ORIENT],
    output logic signed [COORD_BITS:0]   o_drx[NUM_ORIENT],
    output logic signed [COORD_BITS:0]   o_dry[NUM_ORIENT],
    output logic signed [COORD_BITS-1:0] o_axlo,
    output logic signed [COORD_BITS-1:0] o_axhi,
    output logic signed [COORD_BITS-1:0] o_aylo,
    output logic signed [COORD_BITS-1:0] o_ayhi,
    output logic signed [COORD_BITS-1:0] o_bxlo,
    output logic signed [COORD_BITS-1:0] o_bxhi,
    output logic signed [COORD_BITS-1:0] o_bylo,
    output logic signed [COORD_BITS-1:0] o_byhi
);

    localparam int W = COORD_BITS + 1;

    logic signed [W-1:0] px[NUM_ORIENT];
    logic signed [W-1:0] py[NUM_ORIENT];
    logic signed [W-1:0] qx[NUM_ORIENT];
    logic signed [W-1:0] qy[NUM_ORIENT];
    logic signed [W-1:0] rx[NUM_ORIENT];
    logic signed [W-1:0] ry[NUM_ORIENT];

    logic                         r_vld;
    logic signed [W-1:0]          r_dqx[NUM_ORIENT];
    logic signed [W-1:0]          r_dqy[NUM_ORIENT];
    logic signed [W-1:0]          r_drx[NUM_ORIENT];
    logic signed [W-1:0]          r_dry[NUM_ORIENT];
    logic signed [COORD_BITS-1:0] r_axlo, r_axhi, r_aylo, r_ayhi;
    logic signed [COORD_BITS-1:0] r_bxlo, r_bxhi, r_bylo, r_byhi;

    // orientation operands: endpoints of one segment against the other's line
    always_comb begin
        px[0] = {i_bx0[COORD_BITS-1], i_bx0};
        py[0] = {i_by0[COORD_BITS-1], i_by0};
        qx[0] = {i_bx1[COORD_BITS-1], i_bx1};
        qy[0] = {i_by1[COORD_BITS-1], i_by1};
        rx[0] = {i_ax0[COORD_BITS-1], i_ax0};
        ry[0] = {i_ay0[COORD_BITS-1], i_ay0};
        px[1] = px[0];
        py[1] = py[0];
        qx[1] = qx[0];
        qy[1] = qy[0];
        rx[1] = {i_ax1[COORD_BITS-1], i_ax1};
        ry[1] = {i_ay1[COORD_BITS-1], i_ay1};
        px[2] = {i_ax0[COORD_BITS-1], i_ax0};
        py[2] = {i_ay0[COORD_BITS-1], i_ay0};
        qx[2] = {i_ax1[COORD_BITS-1], i_ax1};
        qy[2] = {i_ay1[COORD_BITS-1], i_ay1};
        rx[2] = {i_bx0[COORD_BITS-1], i_bx0};
        ry[2] = {i_by0[COORD_BITS-1], i_by0};
        px[3] = px[2];
        py[3] = py[2];
        qx[3] = qx[2];
        qy[3] = qy[2];
        rx[3] = {i_bx1[COORD_BITS-1], i_bx1};
        ry[3] = {i_by1[COORD_BITS-1], i_by1};
    end

    // stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_ctl.en) begin
            r_vld <= i_ctl.vld;
        end
    end

    // differences and ordered endpoint ranges
    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            for (int k = 0; k < NUM_ORIENT; k++) begin
                r_dqx[k] <= qx[k] - px[k];
                r_dqy[k] <= qy[k] - py[k];
                r_drx[k] <= rx[k] - px[k];
                r_dry[k] <= ry[k] - py[k];
            end
            r_axlo <= (i_ax0 < i_ax1) ? i_ax0 : i_ax1;
            r_axhi <= (i_ax0 < i_ax1) ? i_ax1 : i_ax0;
            r_aylo <= (i_ay0 < i_ay1) ? i_ay0 : i_ay1;
            r_ayhi <= (i_ay0 < i_ay1) ? i_ay1 : i_ay0;
            r_bxlo <= (i_bx0 < i_bx1) ? i_bx0 : i_bx1;
            r_bxhi <= (i_bx0 < i_bx1) ? i_bx1 : i_bx0;
            r_bylo <= (i_by0 < i_by1) ? i_by0 : i_by1;
            r_byhi <= (i_by0 < i_by1) ? i_by1 : i_by0;
        end
    end

    assign o_vld  = r_vld;
    assign o_dqx  = r_dqx;
    assign o_dqy  = r_dqy;
    assign o_drx  = r_drx;
    assign o_dry  = r_dry;
    assign o_axlo = r_axlo;
    assign o_axhi = r_axhi;
    assign o_aylo = r_aylo;
    assign o_ayhi = r_ayhi;
    assign o_bxlo = r_bxlo;
    assign o_bxhi = r_bxhi;
    assign o_bylo = r_bylo;
    assign o_byhi = r_byhi;

endmodule

[hdl/segx_mul.sv]
module segx_mul
    import segx_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  t_pipe_ctl                      i_ctl,
    input  logic signed [COORD_BITS:0]     i_dqx[NUM_ORIENT],
    input  logic signed [COORD_BITS:0]     i_dqy[NUM_ORIENT],
    input  logic signed [COORD_BITS:0]     i_drx[NUM_ORIENT],
    input  logic signed [COORD_BITS:0]     i_dry[NUM_ORIENT],
    input  logic signed [COORD_BITS-1:0]   i_axlo,
    input  logic signed [COORD_BITS-1:0]   i_axhi,
    input  logic signed [COORD_BITS-1:0]   i_aylo,
    input  logic signed [COORD_BITS-1:0]   i_ayhi,
    input  logic signed [COORD_BITS-1:0]   i_bxlo,
    input  logic signed [COORD_BITS-1:0]   i_bxhi,
    input  logic signed [COORD_BITS-1:0]   i_bylo,
    input  logic signed [COORD_BITS-1:0]   i_byhi,
    output logic                           o_vld,
    output logic signed [2*COORD_BITS+1:0] o_t1[NUM_ORIENT],
    output logic signed [2*COORD_BITS+1:0] o_t2[NUM_ORIENT],
    output logic                           o_rng
);

    localparam int PW = 2 * COORD_BITS + 2;

    logic                r_vld;
    logic signed [PW-1:0] r_t1[NUM_ORIENT];
    logic signed [PW-1:0] r_t2[NUM_ORIENT];
    logic                r_rng;
    logic                rng_x;
    logic                rng_y;

    // collinear overlap: x ranges and y ranges must both meet
    assign rng_x = (i_bxlo <= i_axhi) && (i_bxhi >= i_axlo);
    assign rng_y = (i_bylo <= i_ayhi) && (i_byhi >= i_aylo);

    // stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_ctl.en) begin
            r_vld <= i_ctl.vld;
        end
    end

    // cross product terms, one multiplier per term
    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            for (int k = 0; k < NUM_ORIENT; k++) begin
                r_t1[k] <= i_dqx[k] * i_dry[k];
                r_t2[k] <= i_dqy[k] * i_drx[k];
            end
            r_rng <= rng_x && rng_y;
        end
    end

    assign o_vld = r_vld;
    assign o_t1  = r_t1;
    assign o_t2  = r_t2;
    assign o_rng = r_rng;

endmodule

[hdl/segx_cmp.sv]
module segx_cmp
    import segx_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  t_pipe_ctl                      i_ctl,
    input  logic signed [2*COORD_BITS+1:0] i_t1[NUM_ORIENT],
    input  logic signed [2*COORD_BITS+1:0] i_t2[NUM_ORIENT],
    input  logic                           i_rng,
    output logic                           o_vld,
    output logic [NUM_ORIENT-1:0]          o_pos,
    output logic [NUM_ORIENT-1:0]          o_neg,
    output logic                           o_rng
);

    localparam int DW = 2 * COORD_BITS + 3;

    logic signed [DW-1:0]  diff[NUM_ORIENT];
    logic                  r_vld;
    logic [NUM_ORIENT-1:0] r_pos;
    logic [NUM_ORIENT-1:0] r_neg;
    logic                  r_rng;

    // one wide subtract per orientation gives its sign
    always_comb begin
        for (int k = 0; k < NUM_ORIENT; k++) begin
            diff[k] = DW'(i_t1[k]) - DW'(i_t2[k]);
        end
    end

    // stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_ctl.en) begin
            r_vld <= i_ctl.vld;
        end
    end

    // orientation signs
    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            for (int k = 0; k < NUM_ORIENT; k++) begin
                r_neg[k] <= diff[k][DW-1];
                r_pos[k] <= !diff[k][DW-1] && (diff[k] != '0);
            end
            r_rng <= i_rng;
        end
    end

    assign o_vld = r_vld;
    assign o_pos = r_pos;
    assign o_neg = r_neg;
    assign o_rng = r_rng;

endmodule

[hdl/segment_intersection_test.sv]
// segment intersection test
//
// Input channel: eight signed coordinates of two closed segments, A given by
// i_ax0/i_ay0 to i_ax1/i_ay1 and B by i_bx0/i_by0 to i_bx1/i_by1. A transfer
// happens on a rising edge with i_valid high and o_stall low.
// Output channel: o_hit is 1 when the segments share at least one point,
// touching and collinear overlap included. A transfer happens on a rising
// edge with o_valid high and i_stall low.
// An input pair passes differences and range ordering, cross product
// multiplies, sign compare, then the decision register that drives o_hit.
// Throughput is one pair per cycle while the receiver does not stall, set
// by the four pipeline registers each taking a new item whenever it moves on.
// When the receiver stalls, the result holds in the output register and
// each earlier stage keeps filling until it holds an item of its own; o_stall
// rises only once every stage is occupied, so nothing is dropped or repeated.
// Reset (synchronous, active low) empties the pipeline; o_valid is low after.
module segment_intersection_test
    import segx_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic signed [COORD_BITS-1:0] i_ax0,
    input  logic signed [COORD_BITS-1:0] i_ay0,
    input  logic signed [COORD_BITS-1:0] i_ax1,
    input  logic signed [COORD_BITS-1:0] i_ay1,
    input  logic signed [COORD_BITS-1:0] i_bx0,
    input  logic signed [COORD_BITS-1:0] i_by0,
    input  logic signed [COORD_BITS-1:0] i_bx1,
    input  logic signed [COORD_BITS-1:0] i_by1,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_hit
);

    logic signed [COORD_BITS:0]     dqx[NUM_ORIENT];
    logic signed [COORD_BITS:0]     dqy[NUM_ORIENT];
    logic signed [COORD_BITS:0]     drx[NUM_ORIENT];
    logic signed [COORD_BITS:0]     dry[NUM_ORIENT];
    logic signed [COORD_BITS-1:0]   axlo, axhi, aylo, ayhi;
    logic signed [COORD_BITS-1:0]   bxlo, bxhi, bylo, byhi;
    logic signed [2*COORD_BITS+1:0] t1[NUM_ORIENT];
    logic signed [2*COORD_BITS+1:0] t2[NUM_ORIENT];
    logic                           rng2;
    logic [NUM_ORIENT-1:0]          pos;
    logic [NUM_ORIENT-1:0]          neg;
    logic                           rng3;

    logic      vld1, vld2, vld3;
    logic      en1, en2, en3, en4;
    t_pipe_ctl ctl1, ctl2, ctl3;

    logic      r_valid;
    logic      r_hit;
    logic      n_hit;
    logic      collinear;
    logic      cross_a;
    logic      cross_b;

    // a stage loads when it is empty or the next stage loads
    assign en4 = !r_valid || !i_stall;
    assign en3 = !vld3 || en4;
    assign en2 = !vld2 || en3;
    assign en1 = !vld1 || en2;

    assign ctl1    = '{en: en1, vld: i_valid};
    assign ctl2    = '{en: en2, vld: vld1};
    assign ctl3    = '{en: en3, vld: vld2};
    assign o_stall = !en1;

    segx_diff #(.COORD_BITS(COORD_BITS)) u_diff (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl1),
        .i_ax0   (i_ax0),
        .i_ay0   (i_ay0),
        .i_ax1   (i_ax1),
        .i_ay1   (i_ay1),
        .i_bx0   (i_bx0),
        .i_by0   (i_by0),
        .i_bx1   (i_bx1),
        .i_by1   (i_by1),
        .o_vld   (vld1),
        .o_dqx   (dqx),
        .o_dqy   (dqy),
        .o_drx   (drx),
        .o_dry   (dry),
        .o_axlo  (axlo),
        .o_axhi  (axhi),
        .o_aylo  (aylo),
        .o_ayhi  (ayhi),
        .o_bxlo  (bxlo),
        .o_bxhi  (bxhi),
        .o_bylo  (bylo),
        .o_byhi  (byhi)
    );

    segx_mul #(.COORD_BITS(COORD_BITS)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl2),
        .i_dqx   (dqx),
        .i_dqy   (dqy),
        .i_drx   (drx),
        .i_dry   (dry),
        .i_axlo  (axlo),
        .i_axhi  (axhi),
        .i_aylo  (aylo),
        .i_ayhi  (ayhi),
        .i_bxlo  (bxlo),
        .i_bxhi  (bxhi),
        .i_bylo  (bylo),
        .i_byhi  (byhi),
        .o_vld   (vld2),
        .o_t1    (t1),
        .o_t2    (t2),
        .o_rng   (rng2)
    );

    segx_cmp #(.COORD_BITS(COORD_BITS)) u_cmp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl3),
        .i_t1    (t1),
        .i_t2    (t2),
        .i_rng   (rng2),
        .o_vld   (vld3),
        .o_pos   (pos),
        .o_neg   (neg),
        .o_rng   (rng3)
    );

    // decision: straddle test, or range overlap when all orientations are zero
    always_comb begin
        collinear = (pos == '0) && (neg == '0);
        cross_a   = !((pos[0] && pos[1]) || (neg[0] && neg[1]));
        cross_b   = !((pos[2] && pos[3]) || (neg[2] && neg[3]));
        n_hit     = collinear ? rng3 : (cross_a && cross_b);
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en4) begin
            r_valid <= vld3;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (en4) begin
            r_hit <= n_hit;
        end
    end

    assign o_valid = r_valid;
    assign o_hit   = r_hit;

endmodule

[hdl/segx_chk.sv]
module segx_chk (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_stall,
    input logic o_valid,
    input logic i_stall,
    input logic o_hit
);

    // a stalled result stays offered
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its value
    a_hold_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_hit))
        else $error("result changed while stalled");

    // an empty output register means the pipeline has room
    a_empty_accepts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled with empty output");

    // a result leaving frees a slot all the way back to the input
    a_drain_accepts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall |-> !o_stall)
        else $error("input stalled while output drains");

endmodule

bind segment_intersection_test segx_chk u_segx_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_hit   (o_hit)
);

[dv/segx_hit_check.sv]
module segx_hit_check #(
    parameter int COORD_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_in_stall,
    input  logic signed [COORD_BITS-1:0] i_ax0,
    input  logic signed [COORD_BITS-1:0] i_ay0,
    input  logic signed [COORD_BITS-1:0] i_ax1,
    input  logic signed [COORD_BITS-1:0] i_ay1,
    input  logic signed [COORD_BITS-1:0] i_bx0,
    input  logic signed [COORD_BITS-1:0] i_by0,
    input  logic signed [COORD_BITS-1:0] i_bx1,
    input  logic signed [COORD_BITS-1:0] i_by1,
    input  logic                         i_out_valid,
    input  logic                         i_out_stall,
    input  logic                         i_hit,
    output int                           o_fail_count,
    output int                           o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    // hit bits predicted for pairs still in flight, oldest first
    logic expected_hits[$];

    // side of point r against the line p->q: +1 left, -1 right, 0 on the line
    function automatic int side_of_line(longint px, longint py, longint qx, longint qy,
                                        longint rx, longint ry);
        longint lhs;
        longint rhs;
        lhs = (qx - px) * (ry - py);
        rhs = (qy - py) * (rx - px);
        if (lhs > rhs)
            return 1;
        if (lhs < rhs)
            return -1;
        return 0;
    endfunction

    // endpoints not strictly on the same side
    function automatic logic not_same_side(int s, int t);
        return !((s > 0 && t > 0) || (s < 0 && t < 0));
    endfunction

    function automatic logic spans_overlap(longint a0, longint a1, longint b0, longint b1);
        longint a_lo;
        longint a_hi;
        longint b_lo;
        longint b_hi;
        a_lo = (a0 < a1) ? a0 : a1;
        a_hi = (a0 < a1) ? a1 : a0;
        b_lo = (b0 < b1) ? b0 : b1;
        b_hi = (b0 < b1) ? b1 : b0;
        return (b_lo <= a_hi) && (b_hi >= a_lo);
    endfunction

    // closed segments a and b share at least one point
    function automatic logic segments_meet(coord_t ax0, coord_t ay0, coord_t ax1, coord_t ay1,
                                           coord_t bx0, coord_t by0, coord_t bx1, coord_t by1);
        int sa0;
        int sa1;
        int sb0;
        int sb1;
        sa0 = side_of_line(bx0, by0, bx1, by1, ax0, ay0);
        sa1 = side_of_line(bx0, by0, bx1, by1, ax1, ay1);
        sb0 = side_of_line(ax0, ay0, ax1, ay1, bx0, by0);
        sb1 = side_of_line(ax0, ay0, ax1, ay1, bx1, by1);
        // all four on one line: fall back to bounding range overlap
        if (sa0 == 0 && sa1 == 0 && sb0 == 0 && sb1 == 0)
            return spans_overlap(ax0, ax1, bx0, bx1) && spans_overlap(ay0, ay1, by0, by1);
        return not_same_side(sa0, sa1) && not_same_side(sb0, sb1);
    endfunction

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // predict on each input transfer, compare on each output transfer
    always @(posedge i_clk) begin
        logic want_hit;
        if (!i_rst_n) begin
            expected_hits.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_hits.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual hit=%0b",
                             $time, i_hit);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want_hit = expected_hits.pop_front();
                    if (i_hit !== want_hit) begin
                        $display("%0t: hit mismatch, expected %0b, actual %0b",
                                 $time, want_hit, i_hit);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                expected_hits.push_back(segments_meet(i_ax0, i_ay0, i_ax1, i_ay1,
                                                      i_bx0, i_by0, i_bx1, i_by1));
            end
        end
        o_pending <= expected_hits.size();
    end

endmodule

[dv/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW           = 16;
    localparam int RST_CYCLES   = 8;
    localparam int NUM_RANDOM   = 600;
    localparam int HOLD_ITEMS   = 48;
    localparam int HOLD_CYCLES  = 64;
    localparam int QUIET_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 12;

    typedef logic signed [CW-1:0] coord_t;

    typedef struct {
        coord_t ax0, ay0, ax1, ay1;
        coord_t bx0, by0, bx1, by1;
    } seg_pair_t;

    typedef enum int {
        GEN_RAW,
        GEN_SMALL,
        GEN_COLLINEAR,
        GEN_TOUCH,
        GEN_EXTREME
    } gen_kind_t;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY
    } stall_mode_t;

    logic   i_clk = 1'b0;
    logic   i_rst_n;
    logic   i_valid;
    logic   o_stall;
    coord_t i_ax0, i_ay0, i_ax1, i_ay1;
    coord_t i_bx0, i_by0, i_bx1, i_by1;
    logic   o_valid;
    logic   i_stall;
    logic   o_hit;

    int fail_count;
    int pending;
    int quiet_cycles = 0;
    bit hold_req = 1'b0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    segment_intersection_test #(
        .COORD_BITS(CW)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_ax0  (i_ax0),
        .i_ay0  (i_ay0),
        .i_ax1  (i_ax1),
        .i_ay1  (i_ay1),
        .i_bx0  (i_bx0),
        .i_by0  (i_by0),
        .i_bx1  (i_bx1),
        .i_by1  (i_by1),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_hit  (o_hit)
    );

    segx_hit_check #(
        .COORD_BITS(CW)
    ) hit_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_in_stall  (o_stall),
        .i_ax0       (i_ax0),
        .i_ay0       (i_ay0),
        .i_ax1       (i_ax1),
        .i_ay1       (i_ay1),
        .i_bx0       (i_bx0),
        .i_by0       (i_by0),
        .i_bx1       (i_bx1),
        .i_by1       (i_by1),
        .i_out_valid (o_valid),
        .i_out_stall (i_stall),
        .i_hit       (o_hit),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    function automatic seg_pair_t make_pair(int ax0, int ay0, int ax1, int ay1,
                                            int bx0, int by0, int bx1, int by1);
        seg_pair_t p;
        p.ax0 = coord_t'(ax0);
        p.ay0 = coord_t'(ay0);
        p.ax1 = coord_t'(ax1);
        p.ay1 = coord_t'(ay1);
        p.bx0 = coord_t'(bx0);
        p.by0 = coord_t'(by0);
        p.bx1 = coord_t'(bx1);
        p.by1 = coord_t'(by1);
        return p;
    endfunction

    function automatic int rand_signed(int r);
        return int'($urandom_range(2 * r)) - r;
    endfunction

    // random pair, weighted toward collinear and touching geometry
    function automatic seg_pair_t random_pair();
        int        extremes[7] = '{-32768, -32767, -1, 0, 1, 32766, 32767};
        int        t[4];
        int        px, py, dx, dy, pick, reach;
        gen_kind_t kind;
        seg_pair_t p;
        seg_pair_t q;
        pick = $urandom_range(99);
        if (pick < 20)
            kind = GEN_RAW;
        else if (pick < 45)
            kind = GEN_SMALL;
        else if (pick < 70)
            kind = GEN_COLLINEAR;
        else if (pick < 90)
            kind = GEN_TOUCH;
        else
            kind = GEN_EXTREME;
        case (kind)
            GEN_RAW: begin
                p = make_pair($urandom, $urandom, $urandom, $urandom,
                              $urandom, $urandom, $urandom, $urandom);
            end
            GEN_SMALL: begin
                p = make_pair(rand_signed(8), rand_signed(8), rand_signed(8), rand_signed(8),
                              rand_signed(8), rand_signed(8), rand_signed(8), rand_signed(8));
            end
            GEN_COLLINEAR: begin
                // all four points on one line through (px,py) along (dx,dy)
                px = rand_signed(20000);
                py = rand_signed(20000);
                dx = rand_signed(8);
                dy = rand_signed(8);
                pick = $urandom_range(2);
                if (pick == 0)
                    dy = 0;
                else if (pick == 1)
                    dx = 0;
                reach = $urandom_range(1) ? 30 : 400;
                foreach (t[i])
                    t[i] = rand_signed(reach);
                p = make_pair(px + t[0] * dx, py + t[0] * dy, px + t[1] * dx, py + t[1] * dy,
                              px + t[2] * dx, py + t[2] * dy, px + t[3] * dx, py + t[3] * dy);
            end
            GEN_TOUCH: begin
                // one endpoint of b on the line of a, on or off the segment
                px = rand_signed(1000);
                py = rand_signed(1000);
                dx = rand_signed(50);
                dy = rand_signed(50);
                foreach (t[i])
                    t[i] = rand_signed(10);
                p = make_pair(px + t[0] * dx, py + t[0] * dy, px + t[1] * dx, py + t[1] * dy,
                              px + t[2] * dx, py + t[2] * dy,
                              rand_signed(2000), rand_signed(2000));
            end
            default: begin
                p = make_pair(extremes[$urandom_range(6)], extremes[$urandom_range(6)],
                              extremes[$urandom_range(6)], extremes[$urandom_range(6)],
                              extremes[$urandom_range(6)], extremes[$urandom_range(6)],
                              extremes[$urandom_range(6)], extremes[$urandom_range(6)]);
            end
        endcase
        // swap the roles of the two segments half the time
        if ($urandom_range(1)) begin
            q = p;
            p.ax0 = q.bx0;
            p.ay0 = q.by0;
            p.ax1 = q.bx1;
            p.ay1 = q.by1;
            p.bx0 = q.ax0;
            p.by0 = q.ay0;
            p.bx1 = q.ax1;
            p.by1 = q.ay1;
        end
        return p;
    endfunction

    // present one pair from a falling edge until its transfer
    task automatic send_pair(seg_pair_t p);
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_ax0   <= p.ax0;
        i_ay0   <= p.ay0;
        i_ax1   <= p.ax1;
        i_ay1   <= p.ay1;
        i_bx0   <= p.bx0;
        i_by0   <= p.by0;
        i_bx1   <= p.bx1;
        i_by1   <= p.by1;
        do
            @(posedge i_clk);
        while (o_stall);
    endtask

    task automatic idle_cycles(int n);
        repeat (n) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
    endtask

    // receiver stall pattern, with one long hold-off on request
    initial begin
        int          hold_left;
        int          mode_left;
        bit          hold_done;
        stall_mode_t mode;
        hold_left = 0;
        mode_left = 0;
        hold_done = 1'b0;
        mode      = STALL_NONE;
        i_stall   = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                i_stall <= 1'b1;
            end else begin
                if (mode_left == 0) begin
                    mode      = stall_mode_t'($urandom_range(2));
                    mode_left = $urandom_range(40, 4);
                end
                mode_left--;
                case (mode)
                    STALL_NONE:  i_stall <= 1'b0;
                    STALL_LIGHT: i_stall <= ($urandom_range(99) < 30);
                    default:     i_stall <= ($urandom_range(99) < 75);
                endcase
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // stimulus and verdict
    initial begin
        seg_pair_t directed_q[$];
        int        burst_left;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ax0   = '0;
        i_ay0   = '0;
        i_ax1   = '0;
        i_ay1   = '0;
        i_bx0   = '0;
        i_by0   = '0;
        i_bx1   = '0;
        i_by1   = '0;
        repeat (RST_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // proper crossing, parallel, t-junction, shared endpoint
        directed_q.push_back(make_pair(-10, -10, 10, 10, -10, 10, 10, -10));
        directed_q.push_back(make_pair(0, 0, 10, 0, 0, 1, 10, 1));
        directed_q.push_back(make_pair(0, 0, 10, 0, 5, 0, 5, 7));
        directed_q.push_back(make_pair(0, 0, 4, 4, 4, 4, 9, -2));
        // b's line crosses a's line outside a
        directed_q.push_back(make_pair(0, 0, 10, 0, 20, 0, 30, 5));
        directed_q.push_back(make_pair(0, 0, 10, 0, 20, -5, 20, 5));
        // collinear horizontal: overlap, touching ends, apart
        directed_q.push_back(make_pair(0, 3, 10, 3, 5, 3, 20, 3));
        directed_q.push_back(make_pair(0, 3, 10, 3, 10, 3, 20, 3));
        directed_q.push_back(make_pair(0, 3, 10, 3, 11, 3, 20, 3));
        // collinear vertical with reversed endpoints
        directed_q.push_back(make_pair(-2, 9, -2, -4, -2, 0, -2, 30));
        directed_q.push_back(make_pair(-2, 9, -2, -4, -2, 10, -2, 30));
        // collinear diagonal
        directed_q.push_back(make_pair(0, 0, 5, 5, 5, 5, 9, 9));
        directed_q.push_back(make_pair(0, 0, 5, 5, 6, 6, 9, 9));
        // single points: equal, same x only, same y only
        directed_q.push_back(make_pair(7, -3, 7, -3, 7, -3, 7, -3));
        directed_q.push_back(make_pair(7, -3, 7, -3, 7, 4, 7, 4));
        directed_q.push_back(make_pair(7, -3, 7, -3, -1, -3, -1, -3));
        // point on the segment, on its line beyond it, off its line
        directed_q.push_back(make_pair(2, 2, 2, 2, 0, 0, 4, 4));
        directed_q.push_back(make_pair(5, 5, 5, 5, 0, 0, 4, 4));
        directed_q.push_back(make_pair(2, 3, 2, 3, 0, 0, 4, 4));
        // full-range coordinates
        directed_q.push_back(make_pair(-32768, -32768, 32767, 32767,
                                       -32768, 32767, 32767, -32768));
        directed_q.push_back(make_pair(32767, 32767, 32767, 32767,
                                       32767, 32767, 32767, 32767));
        directed_q.push_back(make_pair(-32768, -32768, -32768, -32768,
                                       -32768, -32768, -32768, -32768));
        directed_q.push_back(make_pair(-32768, 0, 32767, 0, 32767, -32768, 32767, 32767));
        directed_q.push_back(make_pair(-32768, -32768, 32767, -32767,
                                       -32768, -32767, 32767, -32766));
        foreach (directed_q[i]) begin
            idle_cycles($urandom_range(1));
            send_pair(directed_q[i]);
        end

        // back-to-back transfers while the receiver holds off
        hold_req = 1'b1;
        for (int n = 0; n < HOLD_ITEMS; n++)
            send_pair(random_pair());

        // random bursts with random gaps
        burst_left = 0;
        for (int n = HOLD_ITEMS; n < NUM_RANDOM; n++) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(30, 1);
                idle_cycles(($urandom_range(3) == 0) ? 0 : $urandom_range(8, 1));
            end
            burst_left--;
            send_pair(random_pair());
        end
        idle_cycles(1);

        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
